FILE: src/apm_pkg.sv
// shared types and constants for the approximate dna pattern matcher
package apm_pkg;

  localparam int TEXT_W       = 8;
  localparam int BASE_W       = 2;
  localparam int PATTERN_W    = 32;
  localparam int NUM_PATTERNS = 4;
  localparam int CODES_PER_REG = PATTERN_W / BASE_W;
  localparam int HITS_W       = 4;
  localparam int OUT_TDATA_W  = 8;
  localparam int CFG_INDEX_W  = 3;

  typedef logic [BASE_W-1:0] base_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  // base code that positions past the pattern register read as
  localparam base_t BASE_PAD = base_t'(0);

  // register indexes
  localparam cfg_index_t REG_PATTERN_A = cfg_index_t'(0);
  localparam cfg_index_t REG_PATTERN_B = cfg_index_t'(1);
  localparam cfg_index_t REG_PATTERN_C = cfg_index_t'(2);
  localparam cfg_index_t REG_PATTERN_D = cfg_index_t'(3);

endpackage

FILE: src/apm_cfg_regs.sv
// pattern registers written through the configuration port
module apm_cfg_regs import apm_pkg::*; (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  cfg_index_t                              cfg_index,
  input  logic [PATTERN_W-1:0]                    cfg_wdata,
  output logic [NUM_PATTERNS-1:0][PATTERN_W-1:0]  patterns
);

  logic [NUM_PATTERNS-1:0][PATTERN_W-1:0] pattern_r;
  logic [NUM_PATTERNS-1:0][PATTERN_W-1:0] pattern_nxt;

  always_comb begin
    pattern_nxt = pattern_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_A: pattern_nxt[0] = cfg_wdata;
        REG_PATTERN_B: pattern_nxt[1] = cfg_wdata;
        REG_PATTERN_C: pattern_nxt[2] = cfg_wdata;
        REG_PATTERN_D: pattern_nxt[3] = cfg_wdata;
        default: ; // unknown index, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
    end else begin
      pattern_r <= pattern_nxt;
    end
  end

  assign patterns = pattern_r;

endmodule

FILE: src/apm_matcher.sv
// edit-distance bit array for one pattern: stored previous column and next-column logic
module apm_matcher import apm_pkg::*; #(
  parameter int PATTERN_LENGTH = 16,
  parameter int MAX_DISTANCE   = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  base_t                code,
  input  logic [PATTERN_W-1:0] pattern,
  output logic [HITS_W-1:0]    hits
);

  localparam int COLS = MAX_DISTANCE + 1;

  logic [PATTERN_LENGTH-1:0][COLS-1:0] prev_r;
  logic [PATTERN_LENGTH-1:0][COLS-1:0] cur;
  logic [PATTERN_LENGTH-1:0]           match;

  for (genvar i = 0; i < PATTERN_LENGTH; i++) begin : g_row
    if (i < CODES_PER_REG) begin : g_code
      assign match[i] = (pattern[BASE_W*i +: BASE_W] == code);
    end else begin : g_pad
      assign match[i] = (code == BASE_PAD);
    end

    if (i == 0) begin : g_first
      assign cur[0][0] = match[0];
      for (genvar j = 1; j < COLS; j++) begin : g_col
        assign cur[0][j] = 1'b1;
      end
    end else begin : g_rest
      assign cur[i][0] = prev_r[i-1][0] & match[i];
      for (genvar j = 1; j < COLS; j++) begin : g_col
        // match or substitution, insertion, deletion
        assign cur[i][j] = (match[i] ? prev_r[i-1][j] : prev_r[i-1][j-1])
                         | prev_r[i][j-1]
                         | cur[i-1][j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (step_en) begin
      prev_r <= cur;
    end
  end

  // exact distance: set at j, clear at j-1
  for (genvar j = 0; j < HITS_W; j++) begin : g_hit
    if (j == 0) begin : g_zero
      assign hits[0] = cur[PATTERN_LENGTH-1][0];
    end else if (j <= MAX_DISTANCE) begin : g_used
      assign hits[j] = cur[PATTERN_LENGTH-1][j] & ~cur[PATTERN_LENGTH-1][j-1];
    end else begin : g_unused
      assign hits[j] = 1'b0;
    end
  end

endmodule

FILE: src/dna_approximate_pattern_matcher.sv
// top level of the approximate dna pattern matcher
//
//  channel | direction | payload (low bit first)             | handshake
//  in_     | input     | tdata[7:0] text_char                 | tvalid/tready
//  out_    | output    | tdata[3:0] distance_hits, [7:4] zero | tvalid/tready
//  cfg_    | input     | wdata[31:0] pattern, index[2:0]      | we only
//
// one word per cycle sustained while the output is not stalled;
// the input register feeds the matcher arrays, whose state steps when the
// word moves into the result register; the deletion chain, MAX_DISTANCE
// ors deep, sets the path length. reset is synchronous and clears the
// stored match bits and patterns. a stalled result holds; the input stage
// still takes a word while it is empty or the result register is empty or
// being drained.
module dna_approximate_pattern_matcher import apm_pkg::*; #(
  parameter int PATTERN_LENGTH = 16,
  parameter int MAX_DISTANCE   = 3,
  parameter int GROUP_SIZE     = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [TEXT_W-1:0]      in_tdata,   // [7:0] text_char
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [3:0] distance_hits
  input  logic                   cfg_we,
  input  cfg_index_t             cfg_index,
  input  logic [PATTERN_W-1:0]   cfg_wdata
);

  logic [NUM_PATTERNS-1:0][PATTERN_W-1:0] patterns;
  logic [GROUP_SIZE-1:0][HITS_W-1:0]      group_hits;
  logic [HITS_W-1:0]                      hits_any;

  logic              in_valid_r, in_valid_nxt;
  base_t             code_r;
  logic              out_valid_r, out_valid_nxt;
  logic [HITS_W-1:0] hits_r;
  logic              in_acc;
  logic              step;

  apm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .patterns  (patterns)
  );

  for (genvar g = 0; g < GROUP_SIZE; g++) begin : g_pat
    apm_matcher #(
      .PATTERN_LENGTH (PATTERN_LENGTH),
      .MAX_DISTANCE   (MAX_DISTANCE)
    ) u_matcher (
      .clk     (clk),
      .rst_n   (rst_n),
      .step_en (step),
      .code    (code_r),
      .pattern (patterns[g]),
      .hits    (group_hits[g])
    );
  end

  always_comb begin
    hits_any = '0;
    for (int g = 0; g < GROUP_SIZE; g++) begin
      hits_any = hits_any | group_hits[g];
    end
  end

  assign step      = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | step;
  assign in_acc    = in_tvalid & in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_acc) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      code_r <= in_tdata[BASE_W:1];
    end
    if (step) begin
      hits_r <= hits_any;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-HITS_W){1'b0}}, hits_r};

endmodule

FILE: src/apm_checker.sv
// port-level checks for the matcher, bound to the top level
module apm_checker import apm_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // pad bits above the hit field stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_TDATA_W-1:HITS_W] == '0))
    else $error("result pad bits set");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // accepted word reaches the result register once the output drains
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid)
    else $error("accepted word did not produce a result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind dna_approximate_pattern_matcher apm_checker u_apm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: dv/dna_approximate_pattern_matcher_test.sv
// testbench for the approximate dna pattern matcher: streaming stimulus, predictor, checker
module dna_approximate_pattern_matcher_test;
  import apm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PATTERN_LENGTH = 16;
  localparam int MAX_DISTANCE   = 3;
  localparam int GROUP_SIZE     = 4;
  localparam int IDLE_PCT       = 32;
  localparam int ITEMS_TOTAL    = 1450;

  // indexes the block has no register behind
  localparam cfg_index_t REG_UNUSED_LO = cfg_index_t'(4);
  localparam cfg_index_t REG_UNUSED_HI = cfg_index_t'(7);

  typedef enum {EDIT_SUBST, EDIT_INSERT, EDIT_DROP} edit_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [TEXT_W-1:0]      in_tdata = '0;      // [7:0] text_char
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;          // [3:0] distance_hits
  logic                   cfg_we = 1'b0;
  cfg_index_t             cfg_index = REG_PATTERN_A;
  logic [PATTERN_W-1:0]   cfg_wdata = '0;

  // predictor copy of the registers and of the previous-column match cells
  logic [PATTERN_W-1:0]   pattern_regs [NUM_PATTERNS] = '{default: '0};
  logic [MAX_DISTANCE:0]  prior_cells [GROUP_SIZE][PATTERN_LENGTH] =
    '{default: '{default: '0}};

  logic [TEXT_W-1:0]      text_backlog [$];
  logic [HITS_W-1:0]      pending_hits [$];
  logic [HITS_W-1:0]      hits_due;
  logic                   steady = 1'b0;
  int                     items_queued = 0;
  int                     failures = 0;

  dna_approximate_pattern_matcher #(
    .PATTERN_LENGTH(PATTERN_LENGTH),
    .MAX_DISTANCE  (MAX_DISTANCE),
    .GROUP_SIZE    (GROUP_SIZE)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // one text character through every pattern's edit-distance column
  function automatic logic [HITS_W-1:0] advance_matcher(input logic [TEXT_W-1:0] text_char);
    int g, i, j;
    base_t code, want;
    logic m;
    logic [MAX_DISTANCE:0] now_cells [PATTERN_LENGTH];
    logic [HITS_W-1:0] hits;
    code = base_t'(text_char >> 1);
    hits = '0;
    for (g = 0; g < GROUP_SIZE; g++) begin
      for (i = 0; i < PATTERN_LENGTH; i++) begin
        want = (i < CODES_PER_REG) ? base_t'(pattern_regs[g] >> (BASE_W * i)) : BASE_PAD;
        m = (want == code);
        if (i == 0) begin
          now_cells[0] = '1;
          now_cells[0][0] = m;
        end else begin
          now_cells[i][0] = prior_cells[g][i-1][0] & m;
          for (j = 1; j <= MAX_DISTANCE; j++) begin
            now_cells[i][j] = (m ? prior_cells[g][i-1][j] : prior_cells[g][i-1][j-1])
                            | prior_cells[g][i][j-1] | now_cells[i-1][j-1];
          end
        end
      end
      for (i = 0; i < PATTERN_LENGTH; i++) prior_cells[g][i] = now_cells[i];
      if (now_cells[PATTERN_LENGTH-1][0]) hits[0] = 1'b1;
      // exactly j edits: reachable with j but not with j-1
      for (j = 1; j <= MAX_DISTANCE && j < HITS_W; j++) begin
        if (now_cells[PATTERN_LENGTH-1][j] && !now_cells[PATTERN_LENGTH-1][j-1]) hits[j] = 1'b1;
      end
    end
    return hits;
  endfunction

  // driver: text words from the backlog, expectation worked out as each word is loaded
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (text_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        pending_hits.push_back(advance_matcher(text_backlog[0]));
        in_tdata  <= text_backlog.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_hits.size() == 0) begin
          $display("%0t: result word with nothing expected, distance_hits actual %h",
                   $time, out_tdata[HITS_W-1:0]);
          failures++;
        end else begin
          hits_due = pending_hits.pop_front();
          if (out_tdata[HITS_W-1:0] !== hits_due) begin
            $display("%0t: distance_hits expected %h actual %h",
                     $time, hits_due, out_tdata[HITS_W-1:0]);
            failures++;
          end
        end
      end
      out_tready <= steady || $urandom_range(99) >= IDLE_PCT;
    end
  end

  function automatic logic [TEXT_W-1:0] text_byte(input base_t code);
    logic [TEXT_W-1:0] b;
    b = TEXT_W'($urandom);
    b[2:1] = code;
    return b;
  endfunction

  task automatic push_byte(input logic [TEXT_W-1:0] b);
    text_backlog.push_back(b);
    items_queued++;
  endtask

  function automatic logic [PATTERN_W-1:0] pattern_value();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return {CODES_PER_REG{base_t'($urandom)}};
      default: return PATTERN_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(input cfg_index_t idx, input logic [PATTERN_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_PATTERN_A: pattern_regs[0] = value;
      REG_PATTERN_B: pattern_regs[1] = value;
      REG_PATTERN_C: pattern_regs[2] = value;
      REG_PATTERN_D: pattern_regs[3] = value;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (text_backlog.size() != 0 || pending_hits.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // a copy of one pattern with a few random edits, after a short random lead-in
  task automatic plant_motif();
    base_t motif [$];
    logic [PATTERN_W-1:0] pat;
    int i, spot;
    pat = pattern_regs[$urandom_range(GROUP_SIZE-1)];
    for (i = 0; i < PATTERN_LENGTH; i++) begin
      motif.push_back(i < CODES_PER_REG ? base_t'(pat >> (BASE_W * i)) : BASE_PAD);
    end
    repeat ($urandom_range(4)) begin
      spot = $urandom_range(motif.size() - 1);
      case (edit_t'($urandom_range(2)))
        EDIT_SUBST:  motif[spot] = motif[spot] + base_t'($urandom_range(1, 3));
        EDIT_INSERT: motif.insert(spot, base_t'($urandom));
        default:     motif.delete(spot);
      endcase
    end
    repeat ($urandom_range(6)) push_byte(text_byte(base_t'($urandom)));
    foreach (motif[k]) push_byte(text_byte(motif[k]));
  endtask

  task automatic fill_text(input int count);
    int target;
    target = items_queued + count;
    while (items_queued < target) begin
      if ($urandom_range(99) < 80) plant_motif();
      else repeat ($urandom_range(1, 20)) push_byte(TEXT_W'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: all registers, a stray index, byte extremes and each base letter
    write_reg(REG_PATTERN_A, '0);
    write_reg(REG_PATTERN_B, '1);
    write_reg(REG_PATTERN_C, 32'h5555_5555);
    write_reg(REG_PATTERN_D, 32'hAAAA_AAAA);
    write_reg(REG_UNUSED_HI, '1);
    end_writes();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h41);
    push_byte(8'h43);
    push_byte(8'h47);
    push_byte(8'h54);
    push_byte(8'h02);
    push_byte(8'h04);
    push_byte(8'h06);
    push_byte(8'hF9);
    // run of base code 0 so pattern a ends with every edit count down to zero
    repeat (16) push_byte(8'h61);

    // no idling on either side for this stretch
    wait_drained();
    write_reg(REG_PATTERN_A, PATTERN_W'($urandom));
    write_reg(REG_PATTERN_B, PATTERN_W'($urandom));
    write_reg(REG_PATTERN_C, PATTERN_W'($urandom));
    write_reg(REG_PATTERN_D, PATTERN_W'($urandom));
    end_writes();
    steady = 1'b1;
    fill_text(300);
    wait_drained();
    steady = 1'b0;

    // extreme patterns; the match cells carry over the register writes
    write_reg(REG_PATTERN_A, '1);
    write_reg(REG_PATTERN_B, '1);
    write_reg(REG_PATTERN_C, '0);
    write_reg(REG_PATTERN_D, '0);
    end_writes();
    fill_text(150);

    while (items_queued < ITEMS_TOTAL) begin
      wait_drained();
      repeat ($urandom_range(1, 4)) begin
        write_reg(cfg_index_t'($urandom_range(REG_PATTERN_A, REG_PATTERN_D)), pattern_value());
      end
      if ($urandom_range(3) == 0) begin
        write_reg(cfg_index_t'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), PATTERN_W'($urandom));
      end
      end_writes();
      fill_text(150);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: dna_approximate_pattern_matcher.f
src/apm_pkg.sv
src/apm_cfg_regs.sv
src/apm_matcher.sv
src/dna_approximate_pattern_matcher.sv
src/apm_checker.sv
dv/dna_approximate_pattern_matcher_test.sv
